// ----- rtl/core/acs_pkg.sv -----
// ----------------------------------------------------------------------------
// acs_pkg
// Shared status codes, opcodes and divider interface types.
// ----------------------------------------------------------------------------
package acs_pkg;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_PRIV = 3'd1,
        ST_INV  = 3'd2,
        ST_ADDR = 3'd3,
        ST_DIV0 = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FN_EXEC = 2'd0,
        FN_WRITE = 2'd1,
        FN_SETREG = 2'd2,
        FN_NONE = 2'd3
    } func_t;

    localparam logic [31:0] OP_NOP  = 32'd0;
    localparam logic [31:0] OP_HALT = 32'd1;
    localparam logic [31:0] OP_LDI  = 32'd2;
    localparam logic [31:0] OP_LDD  = 32'd3;
    localparam logic [31:0] OP_LDX  = 32'd4;
    localparam logic [31:0] OP_STD  = 32'd5;
    localparam logic [31:0] OP_STX  = 32'd6;
    localparam logic [31:0] OP_XA   = 32'd7;
    localparam logic [31:0] OP_AX   = 32'd8;
    localparam logic [31:0] OP_INCX = 32'd9;
    localparam logic [31:0] OP_ADD  = 32'd10;
    localparam logic [31:0] OP_SUB  = 32'd11;
    localparam logic [31:0] OP_MUL  = 32'd12;
    localparam logic [31:0] OP_DIV  = 32'd13;
    localparam logic [31:0] OP_REM  = 32'd14;
    localparam logic [31:0] OP_NEG  = 32'd15;
    localparam logic [31:0] OP_JMP  = 32'd16;
    localparam logic [31:0] OP_JZ   = 32'd17;
    localparam logic [31:0] OP_JNZ  = 32'd18;
    localparam logic [31:0] OP_LAST = 32'd21;

    typedef struct packed {
        logic        start;
        logic        want_rem;
        logic [31:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } div_rsp_t;

endpackage

// ----- rtl/core/acs_ram.sv -----
// ----------------------------------------------------------------------------
// acs_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module acs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- rtl/core/acs_div.sv -----
// ----------------------------------------------------------------------------
// acs_div
// Iterative signed divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module acs_div (
    input  logic               clk,
    input  logic               rst_n,
    input  acs_pkg::div_req_t  req,
    output acs_pkg::div_rsp_t  rsp
);

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] den_reg;
    logic        qneg_reg;
    logic        rneg_reg;
    logic        want_rem_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic [32:0] shifted;

    assign shifted = {rem_reg, quo_reg[31]};
    assign trial   = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg     <= 1'b1;
                cnt_reg      <= 6'd32;
                quo_reg      <= req.num[31] ? 32'd0 - req.num : req.num;
                den_reg      <= req.den[31] ? 32'd0 - req.den : req.den;
                rem_reg      <= '0;
                qneg_reg     <= req.num[31] ^ req.den[31];
                rneg_reg     <= req.num[31];
                want_rem_reg <= req.want_rem;
            end
            else if (busy_reg)
            begin
                if (!trial[32])
                begin
                    rem_reg <= trial[31:0];
                end
                else
                begin
                    rem_reg <= shifted[31:0];
                end
                quo_reg <= {quo_reg[30:0], ~trial[32]};
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        if (want_rem_reg)
        begin
            rsp.result = rneg_reg ? 32'd0 - rem_reg : rem_reg;
        end
        else
        begin
            rsp.result = qneg_reg ? 32'd0 - quo_reg : quo_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) req.start |=> busy_reg)
        else $error("divider did not start");
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("divider done while busy");
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> cnt_reg != 6'd0)
        else $error("divider count underflow");

endmodule

// ----- rtl/core/accumulator_cpu_step_unit.sv -----
// ----------------------------------------------------------------------------
// accumulator_cpu_step_unit
// One step of an accumulator machine over an internal word memory.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries a beat of func, addr, data, x_value.
// Output channel out_valid/out_stall carries status, pc_out, acc_out, x_out
// and stop_pc, one result beat per input beat, in order.
// One item at a time: func 1 and 2 go straight to the done state; an execute
// beat makes up to three serial reads of the single-port word memory
// (opcode, operand, data word); divide and remainder also wait on the
// bit-serial divider. in_stall is high while an item is in work or
// its result has not been taken. While out_stall is high the result holds.
// Reset clears PC, A, X, stop PC and the sticky status; memory contents are
// not cleared and must be written before they are read.
// ----------------------------------------------------------------------------
module accumulator_cpu_step_unit #(
    parameter int MEM_WORDS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [9:0]  addr,
    input  logic signed [31:0] data,
    input  logic signed [31:0] x_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic signed [31:0] pc_out,
    output logic signed [31:0] acc_out,
    output logic signed [31:0] x_out,
    output logic signed [31:0] stop_pc
);

    localparam int AW = $clog2(MEM_WORDS);

    typedef enum logic [3:0] {
        S_IDLE, S_FETCH, S_DECODE, S_OPND, S_DATA, S_MUL, S_DIVW, S_DONE
    } state_t;

    state_t      state_reg;
    logic [31:0] pc_reg, a_reg, x_reg, stop_reg, op_reg, prod_reg;
    logic [2:0]  sticky_reg, status_reg;
    logic        out_valid_reg;

    logic           ram_we;
    logic [AW-1:0]  ram_addr;
    logic [31:0]    ram_wdata, ram_rdata;
    logic [31:0]    ea;
    acs_pkg::div_req_t div_req;
    acs_pkg::div_rsp_t div_rsp;

    function automatic logic in_range(input logic [31:0] a);
        in_range = a < 32'(MEM_WORDS);
    endfunction

    acs_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    acs_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    assign ea = (ram_rdata + ((op_reg == acs_pkg::OP_LDX || op_reg == acs_pkg::OP_STX)
                ? x_reg : 32'd0));

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = pc_reg[AW-1:0];
        ram_wdata = a_reg;
        div_req.start    = 1'b0;
        div_req.want_rem = (op_reg == acs_pkg::OP_REM);
        div_req.num      = a_reg;
        div_req.den      = ram_rdata;
        unique case (state_reg)
            S_IDLE:
            begin
                ram_we    = in_valid && func == acs_pkg::FN_WRITE && in_range(32'(addr));
                ram_addr  = AW'(addr);
                ram_wdata = data;
            end
            S_DECODE: ram_addr = AW'(pc_reg + 32'd1);
            S_OPND:
            begin
                ram_addr = AW'(ea);
                ram_we   = in_range(ea) &&
                           (op_reg == acs_pkg::OP_STD || op_reg == acs_pkg::OP_STX);
            end
            S_DATA:
                div_req.start = (op_reg == acs_pkg::OP_DIV || op_reg == acs_pkg::OP_REM)
                                && ram_rdata != 32'd0;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            a_reg         <= '0;
            x_reg         <= '0;
            stop_reg      <= '0;
            sticky_reg    <= acs_pkg::ST_OK;
            status_reg    <= acs_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        status_reg <= acs_pkg::ST_OK;
                        state_reg  <= S_DONE;
                        if (func == acs_pkg::FN_EXEC)
                        begin
                            if (in_range(pc_reg))
                            begin
                                state_reg <= S_FETCH;
                            end
                            else
                            begin
                                status_reg <= acs_pkg::ST_ADDR;
                                sticky_reg <= acs_pkg::ST_ADDR;
                                stop_reg   <= pc_reg;
                            end
                        end
                        else if (func == acs_pkg::FN_SETREG)
                        begin
                            pc_reg <= 32'(addr);
                            a_reg  <= data;
                            x_reg  <= x_value;
                        end
                    end
                S_FETCH: state_reg <= S_DECODE;
                S_DECODE:
                begin
                    op_reg     <= ram_rdata;
                    state_reg  <= S_DONE;
                    status_reg <= sticky_reg;
                    if (ram_rdata == acs_pkg::OP_NOP || ram_rdata == acs_pkg::OP_XA ||
                        ram_rdata == acs_pkg::OP_AX || ram_rdata == acs_pkg::OP_INCX ||
                        ram_rdata == acs_pkg::OP_NEG)
                    begin
                        pc_reg <= pc_reg + 32'd1;
                        if (ram_rdata == acs_pkg::OP_XA) x_reg <= a_reg;
                        if (ram_rdata == acs_pkg::OP_AX) a_reg <= x_reg;
                        if (ram_rdata == acs_pkg::OP_INCX) x_reg <= x_reg + 32'd1;
                        if (ram_rdata == acs_pkg::OP_NEG) a_reg <= 32'd0 - a_reg;
                    end
                    else if (ram_rdata == acs_pkg::OP_HALT)
                    begin
                        stop_reg   <= pc_reg;
                        status_reg <= acs_pkg::ST_PRIV;
                    end
                    else if (ram_rdata > acs_pkg::OP_LAST)
                    begin
                        stop_reg   <= pc_reg;
                        status_reg <= acs_pkg::ST_INV;
                        sticky_reg <= acs_pkg::ST_INV;
                    end
                    else if (ram_rdata > acs_pkg::OP_JNZ)
                    begin
                        stop_reg   <= pc_reg;
                        status_reg <= acs_pkg::ST_PRIV;
                        sticky_reg <= acs_pkg::ST_PRIV;
                    end
                    else if ((ram_rdata == acs_pkg::OP_JZ || ram_rdata == acs_pkg::OP_JNZ) &&
                             ((ram_rdata == acs_pkg::OP_JZ) != (a_reg == 32'd0)))
                    begin
                        pc_reg <= pc_reg + 32'd2;
                    end
                    else if (!in_range(pc_reg + 32'd1))
                    begin
                        stop_reg   <= pc_reg;
                        status_reg <= acs_pkg::ST_ADDR;
                        sticky_reg <= acs_pkg::ST_ADDR;
                    end
                    else
                    begin
                        state_reg <= S_OPND;
                    end
                end
                S_OPND:
                begin
                    state_reg  <= S_DONE;
                    status_reg <= acs_pkg::ST_OK;
                    if (op_reg >= acs_pkg::OP_JMP)
                    begin
                        pc_reg     <= ram_rdata;
                        sticky_reg <= acs_pkg::ST_OK;
                    end
                    else if (op_reg == acs_pkg::OP_LDI)
                    begin
                        a_reg      <= ram_rdata;
                        pc_reg     <= pc_reg + 32'd2;
                        sticky_reg <= acs_pkg::ST_OK;
                    end
                    else if (!in_range(ea))
                    begin
                        stop_reg   <= pc_reg;
                        status_reg <= acs_pkg::ST_ADDR;
                        sticky_reg <= acs_pkg::ST_ADDR;
                    end
                    else if (op_reg == acs_pkg::OP_STD || op_reg == acs_pkg::OP_STX)
                    begin
                        pc_reg     <= pc_reg + 32'd2;
                        sticky_reg <= acs_pkg::ST_OK;
                    end
                    else
                    begin
                        state_reg <= S_DATA;
                    end
                end
                S_DATA:
                begin
                    state_reg <= S_DONE;
                    if ((op_reg == acs_pkg::OP_DIV || op_reg == acs_pkg::OP_REM) &&
                        ram_rdata == 32'd0)
                    begin
                        stop_reg   <= pc_reg;
                        status_reg <= acs_pkg::ST_DIV0;
                        sticky_reg <= acs_pkg::ST_DIV0;
                    end
                    else if (op_reg == acs_pkg::OP_DIV || op_reg == acs_pkg::OP_REM)
                    begin
                        state_reg <= S_DIVW;
                    end
                    else if (op_reg == acs_pkg::OP_MUL)
                    begin
                        prod_reg  <= a_reg * ram_rdata;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        case (op_reg)
                            acs_pkg::OP_ADD: a_reg <= a_reg + ram_rdata;
                            acs_pkg::OP_SUB: a_reg <= a_reg - ram_rdata;
                            default:         a_reg <= ram_rdata;
                        endcase
                        pc_reg     <= pc_reg + 32'd2;
                        sticky_reg <= acs_pkg::ST_OK;
                    end
                end
                S_MUL:
                begin
                    a_reg      <= prod_reg;
                    pc_reg     <= pc_reg + 32'd2;
                    sticky_reg <= acs_pkg::ST_OK;
                    state_reg  <= S_DONE;
                end
                S_DIVW:
                    if (div_rsp.done)
                    begin
                        a_reg      <= div_rsp.result;
                        pc_reg     <= pc_reg + 32'd2;
                        sticky_reg <= acs_pkg::ST_OK;
                        state_reg  <= S_DONE;
                    end
                S_DONE:
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                    else if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign pc_out    = pc_reg;
    assign acc_out   = a_reg;
    assign x_out     = x_reg;
    assign stop_pc   = stop_reg;

    assert property (@(posedge clk) disable iff (!rst_n) out_valid_reg |-> state_reg == S_DONE)
        else $error("result shown outside done state");
    assert property (@(posedge clk) disable iff (!rst_n) ram_we |-> state_reg == S_IDLE ||
                     state_reg == S_OPND)
        else $error("unexpected memory write");
    assert property (@(posedge clk) disable iff (!rst_n) div_req.start |=> state_reg == S_DIVW)
        else $error("divide started without wait");
    assert property (@(posedge clk) disable iff (!rst_n) out_valid_reg && !out_stall |=>
                     !out_valid_reg)
        else $error("result repeated");

endmodule
